// ===== hw/rtl/nearest_palette_colour_top_defines.svh =====
// assertion macros for the nearest palette colour block
`ifndef NEAREST_PALETTE_COLOUR_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOUR_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define NPC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npc same-cycle check failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npc next-cycle check failed");

`endif

// ===== hw/rtl/npc_pkg.sv =====
// shared types and constants for the nearest palette colour block
package npc_pkg;

    localparam int unsigned PALETTE_DEPTH = 256;
    localparam int unsigned ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam int unsigned COMP_W = 8;
    localparam int unsigned METRIC_W = 20;
    localparam int unsigned COUNT_CFG_W = 9;

    localparam logic [9:0] RM_BIAS_R = 10'd512;
    localparam logic [9:0] RM_BIAS_B = 10'd767;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [7:0] index_t;
    typedef logic [METRIC_W-1:0] metric_t;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic  valid;
        logic  last;
        addr_t idx;
    } tag_t;

endpackage

// ===== hw/rtl/npc_metric.sv =====
// four-stage redmean metric pipeline between a pixel and one palette entry
module npc_metric
(
    input  logic            clk,
    input  logic            rst_n,
    input  npc_pkg::rgb_t   pixel,
    input  npc_pkg::rgb_t   entry,
    input  npc_pkg::tag_t   tag_in,
    output npc_pkg::tag_t   tag_out,
    output npc_pkg::metric_t metric
);

    logic [8:0] red_sum;
    logic [7:0] rm;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;

    npc_pkg::tag_t tag_s1_reg;
    npc_pkg::tag_t tag_s2_reg;
    npc_pkg::tag_t tag_s3_reg;
    npc_pkg::tag_t tag_out_reg;

    logic [9:0]  wr_s1_reg;
    logic [9:0]  wb_s1_reg;
    logic [7:0]  dr_s1_reg;
    logic [7:0]  dg_s1_reg;
    logic [7:0]  db_s1_reg;

    logic [9:0]  wr_s2_reg;
    logic [9:0]  wb_s2_reg;
    logic [15:0] sqr_s2_reg;
    logic [15:0] sqg_s2_reg;
    logic [15:0] sqb_s2_reg;

    logic [25:0] pr_s3_reg;
    logic [25:0] pb_s3_reg;
    logic [17:0] tg_s3_reg;

    npc_pkg::metric_t metric_reg;

    assign red_sum = {1'b0, pixel.red} + {1'b0, entry.red};
    assign rm = red_sum[8:1];
    assign dr = (pixel.red >= entry.red) ? (pixel.red - entry.red) : (entry.red - pixel.red);
    assign dg = (pixel.green >= entry.green) ? (pixel.green - entry.green)
                                             : (entry.green - pixel.green);
    assign db = (pixel.blue >= entry.blue) ? (pixel.blue - entry.blue)
                                           : (entry.blue - pixel.blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_s1_reg <= '0;
            tag_s2_reg <= '0;
            tag_s3_reg <= '0;
            tag_out_reg <= '0;
        end
        else
        begin
            tag_s1_reg <= tag_in;
            tag_s2_reg <= tag_s1_reg;
            tag_s3_reg <= tag_s2_reg;
            tag_out_reg <= tag_s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // weights and absolute differences
        wr_s1_reg <= npc_pkg::RM_BIAS_R + {2'b00, rm};
        wb_s1_reg <= npc_pkg::RM_BIAS_B - {2'b00, rm};
        dr_s1_reg <= dr;
        dg_s1_reg <= dg;
        db_s1_reg <= db;
        // squares
        wr_s2_reg <= wr_s1_reg;
        wb_s2_reg <= wb_s1_reg;
        sqr_s2_reg <= dr_s1_reg * dr_s1_reg;
        sqg_s2_reg <= dg_s1_reg * dg_s1_reg;
        sqb_s2_reg <= db_s1_reg * db_s1_reg;
        // weighted terms
        pr_s3_reg <= wr_s2_reg * sqr_s2_reg;
        pb_s3_reg <= wb_s2_reg * sqb_s2_reg;
        tg_s3_reg <= {sqg_s2_reg, 2'b00};
        // sum
        metric_reg <= npc_pkg::metric_t'(pr_s3_reg[25:8]) + npc_pkg::metric_t'(tg_s3_reg)
                    + npc_pkg::metric_t'(pb_s3_reg[25:8]);
    end

    assign tag_out = tag_out_reg;
    assign metric = metric_reg;

endmodule

// ===== hw/rtl/nearest_palette_colour_top.sv =====
// top level of the nearest palette colour block: palette memory, query sequencer, min search
//
// usage
//   input: a transaction is taken on a rising edge with start high and busy low.
//     mode 0 loads red/green/blue into palette slot entry_index; no result, busy stays low.
//     mode 1 queries the pixel against the first palette_count entries.
//   config: cfg_data holds palette_count, written when cfg_valid and cfg_ready are high;
//     cfg_ready is low while a query runs. values above the palette depth saturate.
//   result: result_valid is high for one cycle with nearest_index, nearest_metric and
//     palette_empty; the receiver cannot stall it and needs no handshake.
// timing
//   a query over n entries reads one entry per cycle from the palette memory's read
//   port, then passes the registered memory read and a four-stage metric pipeline;
//   busy falls with the result strobe, so the next query is taken only once the
//   result of the last one is out. with palette_count 0 the result, flagged empty,
//   comes on the next cycle and busy never rises.
// reset
//   rst_n clears the sequencer, busy and palette_count; palette contents stay undefined
//   until loaded, so queries must only cover loaded entries.
`include "nearest_palette_colour_top_defines.svh"

module nearest_palette_colour_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    output logic        result_valid,
    output logic [7:0]  nearest_index,
    output logic [19:0] nearest_metric,
    output logic        palette_empty
);

    npc_pkg::rgb_t palette_mem [npc_pkg::PALETTE_DEPTH];

    logic [npc_pkg::COUNT_CFG_W-1:0] palette_count_reg;
    logic busy_reg;
    logic issuing_reg;
    npc_pkg::cnt_t issue_cnt_reg;
    npc_pkg::cnt_t count_reg;
    npc_pkg::rgb_t pixel_reg;
    npc_pkg::rgb_t rd_data_reg;
    npc_pkg::tag_t rd_tag_reg;
    npc_pkg::metric_t best_metric_reg;
    npc_pkg::addr_t best_idx_reg;
    logic result_valid_reg;
    npc_pkg::index_t nearest_index_reg;
    npc_pkg::metric_t nearest_metric_reg;
    logic palette_empty_reg;

    logic accept;
    logic load_wr;
    logic query_go;
    logic query_empty;
    npc_pkg::cnt_t count_sat;
    npc_pkg::addr_t rd_addr;
    npc_pkg::cnt_t issue_cnt_next;
    logic issue_last;
    npc_pkg::tag_t issue_tag;
    npc_pkg::tag_t m_tag;
    npc_pkg::metric_t m_metric;
    logic take;
    npc_pkg::metric_t sel_metric;
    npc_pkg::addr_t sel_idx;

    assign accept = start & ~busy_reg;
    assign load_wr = accept & (mode == npc_pkg::MODE_LOAD)
                   & (32'(entry_index) < npc_pkg::PALETTE_DEPTH);
    assign count_sat = (32'(palette_count_reg) > npc_pkg::PALETTE_DEPTH)
                     ? npc_pkg::cnt_t'(npc_pkg::PALETTE_DEPTH)
                     : npc_pkg::cnt_t'(palette_count_reg);
    assign query_go = accept & (mode == npc_pkg::MODE_QUERY) & (count_sat != '0);
    assign query_empty = accept & (mode == npc_pkg::MODE_QUERY) & (count_sat == '0);

    assign rd_addr = issue_cnt_reg[npc_pkg::ADDR_W-1:0];
    assign issue_cnt_next = issue_cnt_reg + npc_pkg::cnt_t'(1);
    assign issue_last = (issue_cnt_next == count_reg);
    assign issue_tag = '{valid: issuing_reg, last: issue_last, idx: rd_addr};

    // palette memory, one write port for loads and one registered read for queries
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            palette_mem[npc_pkg::addr_t'(entry_index)] <= '{red: red, green: green, blue: blue};
        end
        rd_data_reg <= palette_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            pixel_reg <= '{red: red, green: green, blue: blue};
            count_reg <= count_sat;
        end
    end

    npc_metric u_metric
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixel   (pixel_reg),
        .entry   (rd_data_reg),
        .tag_in  (rd_tag_reg),
        .tag_out (m_tag),
        .metric  (m_metric)
    );

    // first entry always wins, later ones only on a strictly smaller metric
    assign take = (m_tag.idx == '0) | (m_metric < best_metric_reg);
    assign sel_metric = take ? m_metric : best_metric_reg;
    assign sel_idx = take ? m_tag.idx : best_idx_reg;

    always_ff @(posedge clk)
    begin
        if (m_tag.valid)
        begin
            best_metric_reg <= sel_metric;
            best_idx_reg <= sel_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= '0;
            busy_reg <= 1'b0;
            issuing_reg <= 1'b0;
            issue_cnt_reg <= '0;
            rd_tag_reg <= '0;
            result_valid_reg <= 1'b0;
            nearest_index_reg <= '0;
            nearest_metric_reg <= '0;
            palette_empty_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid & ~busy_reg)
            begin
                palette_count_reg <= cfg_data;
            end
            rd_tag_reg <= issue_tag;

            if (query_go)
            begin
                busy_reg <= 1'b1;
                issuing_reg <= 1'b1;
                issue_cnt_reg <= '0;
            end
            else if (issuing_reg)
            begin
                issue_cnt_reg <= issue_cnt_next;
                if (issue_last)
                begin
                    issuing_reg <= 1'b0;
                end
            end

            result_valid_reg <= 1'b0;
            if (query_empty)
            begin
                result_valid_reg <= 1'b1;
                nearest_index_reg <= '0;
                nearest_metric_reg <= '0;
                palette_empty_reg <= 1'b1;
            end
            else if (m_tag.valid & m_tag.last)
            begin
                result_valid_reg <= 1'b1;
                nearest_index_reg <= npc_pkg::index_t'(sel_idx);
                nearest_metric_reg <= sel_metric;
                palette_empty_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign cfg_ready = ~busy_reg;
    assign result_valid = result_valid_reg;
    assign nearest_index = nearest_index_reg;
    assign nearest_metric = nearest_metric_reg;
    assign palette_empty = palette_empty_reg;

    // sequencer and pipeline only run inside a query
    `NPC_ASSERT_SAME(a_issue_in_query, issuing_reg, busy_reg)
    `NPC_ASSERT_SAME(a_pipe_in_query, m_tag.valid, busy_reg)
    // an empty palette answers on the next cycle without going busy
    `NPC_ASSERT_NEXT(a_empty_answer, query_empty, result_valid_reg && palette_empty_reg && !busy_reg)
    // a searched result releases the block in the same cycle
    `NPC_ASSERT_SAME(a_result_frees, result_valid_reg && !palette_empty_reg, !busy_reg && !issuing_reg)

endmodule
